// ===== rtl/core/sidasc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sidasc_pkg
// Types, constants and the shift-and-add-3 step shared by the signed integer
// to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sidasc_pkg;

  localparam int unsigned BinW        = 32;
  localparam int unsigned BcdDigits   = 10;
  localparam int unsigned BcdW        = 4 * BcdDigits;
  localparam int unsigned DabbleSteps = 4;
  localparam int unsigned NumStages   = BinW / DabbleSteps;

  localparam int unsigned CharW  = 7;
  localparam int unsigned PosW   = 5;

  localparam logic [CharW-1:0] ChMinus = 7'h2D;
  localparam logic [CharW-1:0] ChSpace = 7'h20;
  localparam logic [CharW-1:0] ChZero  = 7'h30;

  // Character positions within one run of twenty.
  localparam logic [PosW-1:0] SignPos       = 5'd0;
  localparam logic [PosW-1:0] FirstDigitPos = 5'd10;
  localparam logic [PosW-1:0] LastPos       = 5'd19;

  typedef struct packed {
    logic            neg;
    logic [BcdW-1:0] bcd;
    logic [BinW-1:0] bin;
  } work_t;

  // Several iterations of the shift-and-add-3 conversion.
  function automatic work_t dabble_steps(work_t w);
    work_t      r;
    logic [3:0] dig;
    r = w;
    for (int s = 0; s < DabbleSteps; s++) begin
      for (int d = 0; d < BcdDigits; d++) begin
        dig = r.bcd[d*4 +: 4];
        if (dig >= 4'd5) begin
          r.bcd[d*4 +: 4] = dig + 4'd3;
        end
      end
      {r.bcd, r.bin} = {r.bcd[BcdW-2:0], r.bin, 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sidasc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sidasc_front
// Input stage: registers the sign and the unsigned magnitude of the value.
// ----------------------------------------------------------------------------
module sidasc_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      up_valid_i,
  input  wire logic [31:0]               value_i,
  output logic                           up_ready_o,
  output logic                           dn_valid_o,
  output sidasc_pkg::work_t              dn_data_o,
  input  wire logic                      dn_ready_i
);

  logic              valid_q, valid_d;
  sidasc_pkg::work_t data_q,  data_d;
  logic              load;

  assign up_ready_o = !valid_q || dn_ready_i;
  assign load       = up_valid_i && up_ready_o;

  always_comb begin
    valid_d = up_ready_o ? up_valid_i : valid_q;
    data_d.neg = value_i[31];
    data_d.bcd = '0;
    data_d.bin = value_i[31] ? (32'd0 - value_i) : value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule
`default_nettype wire

// ===== rtl/core/sidasc_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sidasc_stage
// One pipeline stage of the binary to BCD conversion: four shift-and-add-3
// iterations between registers.
// ----------------------------------------------------------------------------
module sidasc_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              up_valid_i,
  input  wire sidasc_pkg::work_t up_data_i,
  output logic                   up_ready_o,
  output logic                   dn_valid_o,
  output sidasc_pkg::work_t      dn_data_o,
  input  wire logic              dn_ready_i
);

  logic              valid_q, valid_d;
  sidasc_pkg::work_t data_q,  data_d;
  logic              load;

  assign up_ready_o = !valid_q || dn_ready_i;
  assign load       = up_valid_i && up_ready_o;
  assign valid_d    = up_ready_o ? up_valid_i : valid_q;
  assign data_d     = sidasc_pkg::dabble_steps(up_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule
`default_nettype wire

// ===== rtl/core/sidasc_serializer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sidasc_serializer
// Holds one converted value, sent as twenty ASCII characters one word per
// cycle when not stalled: sign, nine padding zeros, then ten BCD digits.
// ----------------------------------------------------------------------------
module sidasc_serializer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              up_valid_i,
  input  wire sidasc_pkg::work_t up_data_i,
  output logic                   up_ready_o,
  output logic                   out_valid_o,
  output logic [6:0]             char_code_o,
  output logic                   last_char_o,
  input  wire logic              out_stall_i
);

  logic                            busy_q, busy_d;
  logic [sidasc_pkg::PosW-1:0]     cnt_q,  cnt_d;
  logic                            neg_q;
  logic [sidasc_pkg::BcdW-1:0]     bcd_q;
  logic                            take, load, at_last;
  logic [3:0]                      dsel;
  logic [3:0]                      digit;

  assign at_last    = (cnt_q == sidasc_pkg::LastPos);
  assign take       = busy_q && !out_stall_i;
  assign up_ready_o = !busy_q || (take && at_last);
  assign load       = up_valid_i && up_ready_o;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (take) begin
      cnt_d = at_last ? '0 : cnt_q + 5'd1;
      if (at_last) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      neg_q <= up_data_i.neg;
      bcd_q <= up_data_i.bcd;
    end
  end

  // The last position carries the least significant digit.
  assign dsel  = 4'(sidasc_pkg::LastPos - cnt_q);
  assign digit = bcd_q[dsel*4 +: 4];

  always_comb begin
    if (cnt_q == sidasc_pkg::SignPos) begin
      char_code_o = neg_q ? sidasc_pkg::ChMinus : sidasc_pkg::ChSpace;
    end else if (cnt_q < sidasc_pkg::FirstDigitPos) begin
      char_code_o = sidasc_pkg::ChZero;
    end else begin
      char_code_o = sidasc_pkg::ChZero + {3'b000, digit};
    end
  end

  assign out_valid_o = busy_q;
  assign last_char_o = at_last;

endmodule
`default_nettype wire

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Formats a signed 32-bit integer as a twenty-character decimal ASCII run.
// ----------------------------------------------------------------------------
// Each accepted value yields twenty words: a sign character ('-' or space)
// and nineteen zero-padded digits of the magnitude, the last word flagged by
// last_char_o. One input register, eight conversion stages of four
// shift-and-add-3 steps each and the character serializer lie in turn
// between acceptance and the first character. The serializer sends one
// character per cycle while out_stall_i is low and takes the next value as
// a run's last character is taken; up to nine more values wait in the
// pipeline while a run is being sent.
module signed_int_to_decimal_ascii (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [6:0]       char_code_o,
  output logic             last_char_o
);

  localparam int unsigned N = sidasc_pkg::NumStages;

  logic              valid   [N+1];
  logic              ready   [N+2];
  sidasc_pkg::work_t data    [N+1];
  logic              front_ready;

  sidasc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (in_valid_i),
    .value_i    (value_i),
    .up_ready_o (front_ready),
    .dn_valid_o (valid[0]),
    .dn_data_o  (data[0]),
    .dn_ready_i (ready[1])
  );

  assign ready[0]   = front_ready;
  assign in_stall_o = !ready[0];

  for (genvar g = 0; g < N; g++) begin : g_stage
    sidasc_stage u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (valid[g]),
      .up_data_i  (data[g]),
      .up_ready_o (ready[g+1]),
      .dn_valid_o (valid[g+1]),
      .dn_data_o  (data[g+1]),
      .dn_ready_i (ready[g+2])
    );
  end

  sidasc_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .up_valid_i  (valid[N]),
    .up_data_i   (data[N]),
    .up_ready_o  (ready[N+1]),
    .out_valid_o (out_valid_o),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o),
    .out_stall_i (out_stall_i)
  );

  // A run is never broken: after a taken word that is not the last, another
  // word follows.
  a_run_continuous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_char_o) |=> out_valid_o)
    else $error("character run broken before its last word");

  // The word after a run's last one, if any, is a sign character.
  a_sign_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_char_o) |=>
      (!out_valid_o || char_code_o == sidasc_pkg::ChMinus ||
       char_code_o == sidasc_pkg::ChSpace))
    else $error("run does not start with a sign character");

  // Every word is a sign character or a decimal digit.
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((char_code_o >= sidasc_pkg::ChZero &&
        char_code_o <= sidasc_pkg::ChZero + 7'd9) ||
       char_code_o == sidasc_pkg::ChMinus || char_code_o == sidasc_pkg::ChSpace))
    else $error("illegal character code");

endmodule
`default_nettype wire
